// ----- src/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the interpolator checker.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tci_pkg.sv -----
// ============================================================================
// Thrust curve interpolator package
// Widths, codes and the command and status bundles between control and datapath.
// ============================================================================
package tci_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int THRUST_W    = 24;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int PROD_W      = TIME_W + THRUST_W;
  localparam int DIV_STEPS   = THRUST_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int S_TDATA_W   = ((TIME_W + THRUST_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((THRUST_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_FULL,
    RES_EMPTY,
    RES_MEM,
    RES_INTERP
  } res_kind_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LAST,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LAST_CMP,
    ST_SCAN,
    ST_PREV,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      load;
    logic      write_pt;
    logic      clear_cnt;
    idx_op_t   idx_op;
    logic      save_hi;
    logic      prep;
    logic      mul;
    logic      div_init;
    logic      div_step;
    res_kind_t res_kind;
    logic      out_load;
  } tci_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             count_zero;
    logic             count_full;
    logic             t_neg;
    logic             ge_last;
    logic             lt_cur;
    logic             idx_zero;
    logic             div_last;
    logic             out_free;
  } tci_stat_t;

endpackage

// ----- src/tci_ctrl.sv -----
// ============================================================================
// Thrust curve interpolator controller
// Sequences appends, clears and queries: last point check, table scan,
// product and serial division, then hands the result to the output word.
// ============================================================================
module tci_ctrl
  import tci_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tci_stat_t stat,
  output tci_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.cmd == CMD_QUERY && !stat.count_zero && !stat.t_neg) begin
          state_next = ST_LAST_CMP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_LAST_CMP: begin
        state_next = stat.ge_last ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.lt_cur) begin
          state_next = stat.idx_zero ? ST_DONE : ST_PREV;
        end
      end
      ST_PREV:     state_next = ST_MUL;
      ST_MUL:      state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (stat.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH:   state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DISPATCH: begin
        case (stat.cmd)
          CMD_APPEND: begin
            if (stat.count_full) begin
              cmd.res_kind = RES_FULL;
            end else begin
              cmd.write_pt = 1'b1;
              cmd.res_kind = RES_ZERO;
            end
          end
          CMD_QUERY: begin
            if (stat.count_zero) begin
              cmd.res_kind = RES_EMPTY;
            end else if (stat.t_neg) begin
              cmd.res_kind = RES_ZERO;
            end else begin
              cmd.idx_op = IDX_LAST;
            end
          end
          CMD_CLEAR: begin
            cmd.clear_cnt = 1'b1;
            cmd.res_kind  = RES_ZERO;
          end
          default: cmd.res_kind = RES_ZERO;
        endcase
      end
      ST_LAST_CMP: begin
        if (stat.ge_last) begin
          cmd.res_kind = RES_MEM;
        end else begin
          cmd.idx_op = IDX_ZERO;
        end
      end
      ST_SCAN: begin
        if (stat.lt_cur) begin
          if (stat.idx_zero) begin
            cmd.res_kind = RES_MEM;
          end else begin
            cmd.save_hi = 1'b1;
            cmd.idx_op  = IDX_DEC;
          end
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      ST_PREV:     cmd.prep     = 1'b1;
      ST_MUL:      cmd.mul      = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_FINISH:   cmd.res_kind = RES_INTERP;
      ST_DONE:     cmd.out_load = stat.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

// ----- src/tci_datapath.sv -----
// ============================================================================
// Thrust curve interpolator datapath
// Point memories, scan index, interpolation product, restoring divider and
// the result and output words.
// ============================================================================
module tci_datapath
  import tci_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tci_cmd_t            cmd,
  output tci_stat_t           stat,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [TIME_W-1:0]   in_time,
  input  logic [THRUST_W-1:0] in_thrust,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [THRUST_W-1:0] out_thrust,
  output logic [STAT_W-1:0]   out_status
);

  logic signed [TIME_W-1:0] time_store [TABLE_DEPTH];
  logic [THRUST_W-1:0]      thrust_store [TABLE_DEPTH];

  logic [CMD_W-1:0]         cmd_reg;
  logic signed [TIME_W-1:0] t_reg;
  logic [THRUST_W-1:0]      thr_in;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         idx_next;
  logic signed [TIME_W-1:0] time_q;
  logic [THRUST_W-1:0]      thrust_q;
  logic signed [TIME_W-1:0] time_hi;
  logic [THRUST_W-1:0]      thr_hi;
  logic [TIME_W-1:0]        diff;
  logic [TIME_W-1:0]        den;
  logic [THRUST_W-1:0]      dmag;
  logic                     dneg;
  logic [THRUST_W-1:0]      base;
  logic [PROD_W-1:0]        product;
  logic [TIME_W-1:0]        rem;
  logic [THRUST_W-1:0]      qsh;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [TIME_W:0]          rem_ext;
  logic [TIME_W:0]          rem_sub;
  logic                     rem_ge;
  logic [THRUST_W-1:0]      res_val;
  logic [STAT_W-1:0]        res_stat;
  logic [CNT_W-1:0]         last_cnt;

  assign last_cnt = count - CNT_W'(1);

  always_comb begin
    case (cmd.idx_op)
      IDX_LAST: idx_next = last_cnt[IDX_W-1:0];
      IDX_ZERO: idx_next = '0;
      IDX_INC:  idx_next = idx + IDX_W'(1);
      IDX_DEC:  idx_next = idx - IDX_W'(1);
      default:  idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write_pt) begin
      time_store[count[IDX_W-1:0]]   <= t_reg;
      thrust_store[count[IDX_W-1:0]] <= thr_in;
    end
    time_q   <= time_store[idx_next];
    thrust_q <= thrust_store[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.clear_cnt) begin
        count <= '0;
      end else if (cmd.write_pt) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_reg <= in_command;
      t_reg   <= in_time;
      thr_in  <= in_thrust;
    end
    if (cmd.save_hi) begin
      time_hi <= time_q;
      thr_hi  <= thrust_q;
    end
    if (cmd.prep) begin
      diff <= TIME_W'(t_reg - time_q);
      den  <= TIME_W'(time_hi - time_q);
      dneg <= thr_hi < thrust_q;
      dmag <= (thr_hi < thrust_q) ? thrust_q - thr_hi : thr_hi - thrust_q;
      base <= thrust_q;
    end
    if (cmd.mul) begin
      product <= PROD_W'(diff) * PROD_W'(dmag);
    end
  end

  // The quotient is below 2^24 because the time offset is below the interval.
  assign rem_ext = {rem, qsh[THRUST_W-1]};
  assign rem_sub = rem_ext - {1'b0, den};
  assign rem_ge  = rem_ext >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= product[PROD_W-1:THRUST_W];
      qsh <= product[THRUST_W-1:0];
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[TIME_W-1:0] : rem_ext[TIME_W-1:0];
      qsh <= {qsh[THRUST_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res_kind)
      RES_ZERO: begin
        res_val  <= '0;
        res_stat <= STATUS_OK;
      end
      RES_FULL: begin
        res_val  <= '0;
        res_stat <= STATUS_FULL;
      end
      RES_EMPTY: begin
        res_val  <= '0;
        res_stat <= STATUS_EMPTY;
      end
      RES_MEM: begin
        res_val  <= thrust_q;
        res_stat <= STATUS_OK;
      end
      RES_INTERP: begin
        res_val  <= dneg ? base - qsh : base + qsh;
        res_stat <= STATUS_OK;
      end
      default: begin
        res_val  <= res_val;
        res_stat <= res_stat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_thrust <= res_val;
      out_status <= res_stat;
    end
  end

  assign stat.cmd        = cmd_reg;
  assign stat.count_zero = count == '0;
  assign stat.count_full = count >= CNT_W'(TABLE_DEPTH);
  assign stat.t_neg      = t_reg[TIME_W-1];
  assign stat.ge_last    = t_reg >= time_q;
  assign stat.lt_cur     = t_reg < time_q;
  assign stat.idx_zero   = idx == '0;
  assign stat.div_last   = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ----- src/thrust_curve_interpolator.sv -----
// ============================================================================
// Thrust curve interpolator
// Stores a thrust curve of time and thrust points and answers time queries by
// piecewise linear interpolation between the two bracketing points.
// ============================================================================
//  Channel  Direction  tdata                           tuser
//  s_*      in         [31:0] time, [55:32] thrust     [1:0] command
//  m_*      out        [23:0] thrust value             [1:0] status
//
// One word is taken at a time. Appends, clears, empty-table and negative-time
// queries load the output register after dispatch, a query at or after the last
// point after the last-point check, one before the first point after a scan step,
// an interpolating query after a one-point-a-cycle scan, the product and a 24-step
// divider. A new word is taken in the cycle after the output loads. Reset empties
// the table. A stalled output holds its word; the next finished word waits for it.
module thrust_curve_interpolator
  import tci_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // sample_time, sample_thrust
  input  logic [CMD_W-1:0]     s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // thrust_value
  output logic [STAT_W-1:0]    m_tuser    // status
);

  tci_cmd_t            cmd;
  tci_stat_t           stat;
  logic [THRUST_W-1:0] out_thrust;

  tci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tci_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (s_tuser),
    .in_time    (s_tdata[TIME_W-1:0]),
    .in_thrust  (s_tdata[TIME_W+THRUST_W-1:TIME_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_thrust (out_thrust),
    .out_status (m_tuser)
  );

  assign m_tdata = M_TDATA_W'(out_thrust);

endmodule

// ----- src/tci_checker.sv -----
// ============================================================================
// Thrust curve interpolator checker
// Port-level assertions, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module tci_checker
  import tci_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [CMD_W-1:0]     s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [STAT_W-1:0]    m_tuser
);

  `TCI_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")
  `TCI_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")
  `TCI_ASSERT(a_status_code, m_tvalid |-> m_tuser == STATUS_OK || m_tuser == STATUS_FULL || m_tuser == STATUS_EMPTY, "unknown status code")
  `TCI_ASSERT(a_err_zero, m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0, "non-zero thrust with error status")
  `TCI_ASSERT(a_one_word, s_tvalid && s_tready |=> !s_tready, "input taken in two consecutive cycles")

endmodule

bind thrust_curve_interpolator tci_checker u_tci_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
